>>> hw/rtl/ecc_pkg.sv
// Shared types, widths and helpers for the ellipse color classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ecc_pkg;

  localparam int CHANNEL_BITS     = 8;
  localparam int COEF_FRAC_BITS   = 20;
  localparam int CENTER_FRAC_BITS = 4;
  localparam int THRESH_FRAC_BITS = 28;

  localparam int NUM_CH      = 3;
  localparam int NUM_TERMS   = 6;
  localparam int CENTER_BITS = 12;
  localparam int COEF_BITS   = 32;
  localparam int THRESH_BITS = 48;

  // APB register file: 64-bit data, registers every 8 bytes
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;

  localparam int Q_FRAC_BITS = 2 * CENTER_FRAC_BITS + COEF_FRAC_BITS;
  localparam int UP_SHIFT    =
      (Q_FRAC_BITS >= THRESH_FRAC_BITS) ? (Q_FRAC_BITS - THRESH_FRAC_BITS) : 0;
  localparam int DOWN_SHIFT  =
      (Q_FRAC_BITS < THRESH_FRAC_BITS) ? (THRESH_FRAC_BITS - Q_FRAC_BITS) : 0;

  // datapath widths, all exact
  localparam int PX_W   = CHANNEL_BITS + CENTER_FRAC_BITS;
  localparam int DIFF_W = ((PX_W > CENTER_BITS) ? PX_W : CENTER_BITS) + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TERM_W = PROD_W + COEF_BITS;
  localparam int ACC_W  = TERM_W + 3;

  localparam int NSTG = 6;

  // operand channels of each quadratic term: 00, 11, 22, 01, 02, 12
  localparam int PAIR_A [NUM_TERMS] = '{0, 1, 2, 0, 0, 1};
  localparam int PAIR_B [NUM_TERMS] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [2:0] {
    REG_CENTER    = 3'd0,
    REG_COEF_00   = 3'd1,
    REG_COEF_11   = 3'd2,
    REG_COEF_22   = 3'd3,
    REG_COEF_01   = 3'd4,
    REG_COEF_02   = 3'd5,
    REG_COEF_12   = 3'd6,
    REG_THRESHOLD = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_CH-1:0][CENTER_BITS-1:0]  center;
    logic [NUM_TERMS-1:0][COEF_BITS-1:0] coef;
    logic [THRESH_BITS-1:0]              threshold;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
  } pipe_ctrl_t;

  // threshold moved to the binary point of the quadratic sum;
  // rounds up when bits drop off so that "q < limit" stays exact
  function automatic logic signed [ACC_W-1:0] align_threshold(
      input logic [THRESH_BITS-1:0] t);
    logic [ACC_W-1:0]       wide;
    logic [THRESH_BITS-1:0] drop_mask;
    wide      = ACC_W'(t);
    drop_mask = (THRESH_BITS'(1) << DOWN_SHIFT) - THRESH_BITS'(1);
    if (Q_FRAC_BITS >= THRESH_FRAC_BITS) begin
      wide = wide << UP_SHIFT;
    end else begin
      wide = (wide >> DOWN_SHIFT) + ACC_W'(|(t & drop_mask));
    end
    return $signed(wide);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ecc_cfg.sv
// APB register file: color center, six coefficients, threshold.
// Depends on ecc_pkg.
`default_nettype none

module ecc_cfg import ecc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic [NUM_CH*CENTER_BITS-1:0]       center;
  logic [NUM_TERMS-1:0][COEF_BITS-1:0] coef;
  logic [THRESH_BITS-1:0]              threshold;
  logic                                wr;
  reg_idx_t                            idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center    <= '0;
      coef      <= '0;
      threshold <= '0;
    end else if (wr) begin
      case (idx)
        REG_CENTER:    center    <= pwdata[NUM_CH*CENTER_BITS-1:0];
        REG_COEF_00:   coef[0]   <= pwdata[COEF_BITS-1:0];
        REG_COEF_11:   coef[1]   <= pwdata[COEF_BITS-1:0];
        REG_COEF_22:   coef[2]   <= pwdata[COEF_BITS-1:0];
        REG_COEF_01:   coef[3]   <= pwdata[COEF_BITS-1:0];
        REG_COEF_02:   coef[4]   <= pwdata[COEF_BITS-1:0];
        REG_COEF_12:   coef[5]   <= pwdata[COEF_BITS-1:0];
        REG_THRESHOLD: threshold <= pwdata[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER:    prdata = DATA_W'(center);
      REG_COEF_00:   prdata = DATA_W'(coef[0]);
      REG_COEF_11:   prdata = DATA_W'(coef[1]);
      REG_COEF_22:   prdata = DATA_W'(coef[2]);
      REG_COEF_01:   prdata = DATA_W'(coef[3]);
      REG_COEF_02:   prdata = DATA_W'(coef[4]);
      REG_COEF_12:   prdata = DATA_W'(coef[5]);
      REG_THRESHOLD: prdata = DATA_W'(threshold);
      default:       prdata = '0;
    endcase
  end

  assign cfg.center    = center;
  assign cfg.coef      = coef;
  assign cfg.threshold = threshold;

endmodule

`default_nettype wire

>>> hw/rtl/ecc_pipe_ctrl.sv
// Valid bits and per-stage load enables; bubbles collapse under stall.
// Depends on ecc_pkg.
`default_nettype none

module ecc_pipe_ctrl import ecc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pix_valid,
  output logic       pix_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output pipe_ctrl_t ctrl
);

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] load;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    load[NSTG-1] = !vld[NSTG-1] || res_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= pix_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pix_ready = load[0];
  assign res_valid = vld[NSTG-1];
  assign ctrl.load = load;

endmodule

`default_nettype wire

>>> hw/rtl/ecc_datapath.sv
// Six-stage datapath: center subtract, pair products, coefficient
// products, two adder levels, threshold compare. Depends on ecc_pkg.
`default_nettype none

module ecc_datapath import ecc_pkg::*; (
  input  logic                    clk,
  input  pipe_ctrl_t              ctrl,
  input  cfg_t                    cfg,
  input  logic [CHANNEL_BITS-1:0] chan0,
  input  logic [CHANNEL_BITS-1:0] chan1,
  input  logic [CHANNEL_BITS-1:0] chan2,
  output logic                    is_inside
);

  logic [CHANNEL_BITS-1:0]  chan [NUM_CH];
  logic signed [DIFF_W-1:0] diff [NUM_CH];
  logic signed [PROD_W-1:0] prod [NUM_TERMS];
  logic signed [TERM_W-1:0] term [NUM_TERMS];
  logic signed [ACC_W-1:0]  psum [NUM_CH];
  logic signed [ACC_W-1:0]  q;
  logic signed [ACC_W-1:0]  limit;

  assign chan[0] = chan0;
  assign chan[1] = chan1;
  assign chan[2] = chan2;
  assign limit   = align_threshold(cfg.threshold);

  // stage 1: d = (chan << 4) - center, signed
  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      for (int k = 0; k < NUM_CH; k++) begin
        diff[k] <= DIFF_W'({chan[k], CENTER_FRAC_BITS'(0)})
                 - DIFF_W'(cfg.center[2'(k)]);
      end
    end
  end

  // stage 2: channel pair products
  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        prod[k] <= diff[2'(PAIR_A[k])] * diff[2'(PAIR_B[k])];
      end
    end
  end

  // stage 3: coefficient products
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      for (int k = 0; k < NUM_TERMS; k++) begin
        term[k] <= $signed(cfg.coef[3'(k)]) * prod[k];
      end
    end
  end

  // stage 4: pairwise sums
  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      for (int j = 0; j < NUM_CH; j++) begin
        psum[j] <= ACC_W'(term[2*j]) + ACC_W'(term[2*j+1]);
      end
    end
  end

  // stage 5: full quadratic value
  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      q <= psum[0] + psum[1] + psum[2];
    end
  end

  // stage 6: compare, output register
  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      is_inside <= q < limit;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ellipse_color_classifier_unit.sv
// Top level of the ellipse color classifier: APB registers, pipeline
// control and datapath. Depends on ecc_pkg, ecc_cfg, ecc_pipe_ctrl, ecc_datapath.
`default_nettype none

// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+------------------------------
// pixel     | in        | pix_valid / pix_ready   | chan0, chan1, chan2 (8b each)
// result    | out       | res_valid / res_ready   | is_inside (1b)
// config    | in        | APB psel/penable/pready | paddr, pwdata, prdata (64b)
//
// One pixel transaction accepted per cycle while pix_ready is high; each pixel
// passes through the six register stages (subtract, pair multiply, coefficient
// multiply, two adder levels, compare into the output register).
// Synchronous active-high rst clears valid bits and all config registers.
// A stalled result stalls only the stages behind it that are full; empty
// stages keep filling, so pix_ready drops only once the pipe is full.

module ellipse_color_classifier_unit import ecc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // pixel channel
  input  logic                    pix_valid,
  output logic                    pix_ready,
  input  logic [CHANNEL_BITS-1:0] chan0,
  input  logic [CHANNEL_BITS-1:0] chan1,
  input  logic [CHANNEL_BITS-1:0] chan2,
  // result channel
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    is_inside,
  // APB config port, register i at byte address 8*i
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  // zero-wait-state config port
  assign pready = 1'b1;

  ecc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // valid bits travel alongside the datapath stages
  ecc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .ctrl      (ctrl)
  );

  ecc_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .chan0     (chan0),
    .chan1     (chan1),
    .chan2     (chan2),
    .is_inside (is_inside)
  );

  // input backpressure only ever comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (res_valid && !res_ready))
    else $error("pix_ready low without a held result");

  // a taken result always frees room for a new pixel
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> pix_ready)
    else $error("pix_ready low while result side is ready");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // a result cannot appear straight out of reset; it needs a pixel taken through the stages
  a_no_early_result: assert property (@(posedge clk)
    rst ##1 !rst [*1] |-> !res_valid)
    else $error("result appeared too early after reset");

endmodule

`default_nettype wire
